>>> src/gcsc_pkg.sv
// Package for the group current share controller: beat types, register indexes,
// reset values and the command and status structs between controller and datapath.
// No dependencies.
package gcsc_pkg;

  localparam int ADDR_W       = 8;
  localparam int MASK_W       = 16;
  localparam int CUR_W        = 16;
  localparam int TIME_W       = 32;
  localparam int LIMIT_W      = 16;
  localparam int STAGGER_W    = 12;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int DIV_CNT_W    = 4;

  localparam int DEF_MEMBER_SLOTS = 16;

  localparam logic [ADDR_W-1:0]    OWN_ADDR_RST = '0;
  localparam logic [LIMIT_W-1:0]   STALE_RST    = LIMIT_W'(500);
  localparam logic [LIMIT_W-1:0]   HOLD_RST     = LIMIT_W'(1000);
  localparam logic [STAGGER_W-1:0] STAGGER_RST  = STAGGER_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDR = 2'd0,
    CFG_STALE    = 2'd1,
    CFG_HOLD     = 2'd2,
    CFG_STAGGER  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    logic [0:0]        op;
    logic [TIME_W-1:0] now_ms;
    logic [ADDR_W-1:0] group_base;
    logic [MASK_W-1:0] member_mask;
    logic [CUR_W-1:0]  group_request;
    logic [CUR_W-1:0]  available_current;
  } in_t;

  typedef struct packed {
    logic [0:0]       deliver;
    logic [CUR_W-1:0] set_current;
  } out_t;

  typedef struct packed {
    logic frame_ld;
    logic tick_ld;
    logic prep;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic stale;
  } status_t;

endpackage

>>> src/group_current_share_control.sv
// Group current share controller, built from the controller gcsc_ctrl and the datapath gcsc_dp,
// with types and constants from gcsc_pkg. A frame beat is taken without a stall and gives no
// result. After its load in the accepting cycle, a tick beat keeps the input stalled through a
// preparation step, the one-bit-per-cycle restoring divider that splits the group request over
// the members and an update step that writes its result to the output register; a tick on stale
// or missing group data skips the remaining divider steps. The update step waits for as long as
// the previous result is still held in the output register by a stall. One beat is worked on at a
// time, and a finished result may wait in the output register while the next beat is accepted.
module group_current_share_control #(
  parameter int MEMBER_SLOTS = gcsc_pkg::DEF_MEMBER_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gcsc_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gcsc_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gcsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  gcsc_pkg::cmd_t    cmd;
  gcsc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  gcsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gcsc_dp #(
    .MEMBER_SLOTS (MEMBER_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> src/gcsc_dp.sv
// Datapath of the group current share controller: configuration registers, group state,
// the bit-serial share divider and the result register.
// Depends on gcsc_pkg.
module gcsc_dp #(
  parameter int MEMBER_SLOTS = gcsc_pkg::DEF_MEMBER_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gcsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gcsc_pkg::in_t                       in_data,
  input  gcsc_pkg::cmd_t                      cmd,
  output gcsc_pkg::status_t                   status,
  output gcsc_pkg::out_t                      out_data
);

  localparam int SLOT_W = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MEMBER_SLOTS + 1);
  localparam int EXT_W  = MEMBER_SLOTS + gcsc_pkg::MASK_W;
  localparam int PROD_W = CNT_W + gcsc_pkg::STAGGER_W;
  localparam int TW     = gcsc_pkg::TIME_W;
  localparam int CW     = gcsc_pkg::CUR_W;

  // Configuration registers.
  logic [gcsc_pkg::ADDR_W-1:0]    own_addr_r;
  logic [gcsc_pkg::LIMIT_W-1:0]   stale_lim_r;
  logic [gcsc_pkg::LIMIT_W-1:0]   hold_r;
  logic [gcsc_pkg::STAGGER_W-1:0] stagger_r;

  // Group state.
  logic                         frame_seen_r, is_member_r, raise_pending_r;
  logic [gcsc_pkg::ADDR_W-1:0]  stored_base_r;
  logic [gcsc_pkg::MASK_W-1:0]  stored_mask_r;
  logic [CW-1:0]                stored_request_r;
  logic [TW-1:0]                join_time_r, frame_time_r, raise_time_r;
  logic [CW-1:0]                granted_r, pending_target_r;

  // Per-tick working registers.
  logic [TW-1:0]     now_r;
  logic [CW-1:0]     avail_r;
  logic              stale_r;
  logic [CNT_W-1:0]  n_r, rank_r, rem_r;
  logic [CW-1:0]     quo_r;
  logic [TW-1:0]     join_el_r, raise_el_r, wait_r;

  // Window and slot of the own address for a given base and mask.
  function automatic logic [MEMBER_SLOTS-1:0] window(input logic [gcsc_pkg::MASK_W-1:0] m);
    logic [EXT_W-1:0] ext;
    ext = {{MEMBER_SLOTS{1'b0}}, m};
    return ext[MEMBER_SLOTS-1:0];
  endfunction

  logic [gcsc_pkg::ADDR_W:0] in_diff, st_diff;
  logic                      in_inwin, st_inwin;
  logic [SLOT_W-1:0]         in_slot, st_slot;
  logic [MEMBER_SLOTS-1:0]   in_win, st_win;
  logic                      in_own;
  logic [CNT_W-1:0]          n_nxt, rank_nxt;

  always_comb begin
    in_diff  = {1'b0, own_addr_r} - {1'b0, in_data.group_base};
    in_inwin = (own_addr_r >= in_data.group_base) &&
               (in_diff < (gcsc_pkg::ADDR_W + 1)'(MEMBER_SLOTS));
    in_slot  = in_diff[SLOT_W-1:0];
    in_win   = window(in_data.member_mask);
    in_own   = in_inwin && in_win[in_slot];

    st_diff  = {1'b0, own_addr_r} - {1'b0, stored_base_r};
    st_inwin = (own_addr_r >= stored_base_r) &&
               (st_diff < (gcsc_pkg::ADDR_W + 1)'(MEMBER_SLOTS));
    st_slot  = st_diff[SLOT_W-1:0];
    st_win   = window(stored_mask_r);
    n_nxt    = '0;
    rank_nxt = '0;
    for (int i = 0; i < MEMBER_SLOTS; i++) begin
      n_nxt    = n_nxt + CNT_W'(st_win[i]);
      rank_nxt = rank_nxt + CNT_W'(st_win[i] && st_inwin && (SLOT_W'(i) < st_slot));
    end
  end

  // One restoring division step.
  logic [CNT_W:0]   rem_sh, rem_sub;
  logic             div_ge;
  always_comb begin
    rem_sh  = {rem_r, quo_r[CW-1]};
    div_ge  = rem_sh >= {1'b0, n_r};
    rem_sub = rem_sh - {1'b0, n_r};
  end

  logic [TW-1:0] frame_age;
  logic [PROD_W-1:0] stag_prod;
  always_comb begin
    frame_age = now_r - frame_time_r;
    stag_prod = PROD_W'(rank_r) * PROD_W'(stagger_r);
  end

  // Share update at the end of a tick.
  logic [CW-1:0] target_raw, target;
  logic          set_now, hold_done, dlv;
  logic [TW-1:0] raise_el;
  logic [CW-1:0] granted_nxt;
  logic          pending_nxt;
  always_comb begin
    target_raw  = (is_member_r && (n_r != '0)) ? quo_r : '0;
    target      = (target_raw > avail_r) ? avail_r : target_raw;
    set_now     = !raise_pending_r || (target > pending_target_r);
    raise_el    = set_now ? '0 : raise_el_r;
    hold_done   = raise_el >= TW'(hold_r);
    granted_nxt = granted_r;
    pending_nxt = raise_pending_r;
    if (target <= granted_r) begin
      granted_nxt = target;
      pending_nxt = 1'b0;
    end else if (hold_done) begin
      granted_nxt = target;
      pending_nxt = 1'b0;
    end else begin
      pending_nxt = 1'b1;
    end
    dlv = is_member_r && (join_el_r >= wait_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r       <= gcsc_pkg::OWN_ADDR_RST;
      stale_lim_r      <= gcsc_pkg::STALE_RST;
      hold_r           <= gcsc_pkg::HOLD_RST;
      stagger_r        <= gcsc_pkg::STAGGER_RST;
      frame_seen_r     <= 1'b0;
      is_member_r      <= 1'b0;
      raise_pending_r  <= 1'b0;
      stored_base_r    <= '0;
      stored_mask_r    <= '0;
      stored_request_r <= '0;
      join_time_r      <= '0;
      frame_time_r     <= '0;
      raise_time_r     <= '0;
      granted_r        <= '0;
      pending_target_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (gcsc_pkg::cfg_idx_t'(cfg_index))
          gcsc_pkg::CFG_OWN_ADDR: own_addr_r  <= cfg_data[gcsc_pkg::ADDR_W-1:0];
          gcsc_pkg::CFG_STALE:    stale_lim_r <= cfg_data[gcsc_pkg::LIMIT_W-1:0];
          gcsc_pkg::CFG_HOLD:     hold_r      <= cfg_data[gcsc_pkg::LIMIT_W-1:0];
          gcsc_pkg::CFG_STAGGER:  stagger_r   <= cfg_data[gcsc_pkg::STAGGER_W-1:0];
          default: ;
        endcase
      end
      if (cmd.frame_ld) begin
        // A module that was not yet a member of live group data joins now.
        if (in_own && !(frame_seen_r && is_member_r)) join_time_r <= in_data.now_ms;
        is_member_r      <= in_own;
        stored_base_r    <= in_data.group_base;
        stored_mask_r    <= in_data.member_mask;
        stored_request_r <= in_data.group_request;
        frame_time_r     <= in_data.now_ms;
        frame_seen_r     <= 1'b1;
      end
      if (cmd.finish) begin
        if (stale_r) begin
          is_member_r     <= 1'b0;
          granted_r       <= '0;
          raise_pending_r <= 1'b0;
        end else begin
          granted_r       <= granted_nxt;
          raise_pending_r <= pending_nxt;
          if (target > granted_r) begin
            pending_target_r <= target;
            if (set_now) raise_time_r <= now_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_ld) begin
      now_r   <= in_data.now_ms;
      avail_r <= in_data.available_current;
    end
    if (cmd.prep) begin
      stale_r    <= !frame_seen_r || (frame_age > TW'(stale_lim_r));
      n_r        <= n_nxt;
      rank_r     <= rank_nxt;
      join_el_r  <= now_r - join_time_r;
      raise_el_r <= now_r - raise_time_r;
      rem_r      <= '0;
      quo_r      <= stored_request_r;
    end
    if (cmd.div_step) begin
      rem_r  <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r  <= {quo_r[CW-2:0], div_ge};
      wait_r <= TW'(hold_r) + TW'(stag_prod);
    end
    if (cmd.finish) begin
      out_data.deliver     <= !stale_r && dlv;
      out_data.set_current <= (!stale_r && dlv) ? granted_nxt : '0;
    end
  end

  assign status.stale = stale_r;

endmodule

>>> src/gcsc_ctrl.sv
// Controller of the group current share controller: sequences the input beat,
// the preparation cycle, the divider steps and the hand-over to the result register.
// Depends on gcsc_pkg.
module gcsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [0:0]        in_op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  gcsc_pkg::status_t status,
  output gcsc_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic [gcsc_pkg::DIV_CNT_W-1:0] LAST_STEP =
    gcsc_pkg::DIV_CNT_W'(gcsc_pkg::CUR_W - 1);

  state_t                          state_r;
  logic [gcsc_pkg::DIV_CNT_W-1:0]  step_r;
  logic                            out_valid_r;
  logic                            out_free;

  // The result register can take a new beat when empty or being emptied this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.frame_ld = (state_r == S_IDLE) && in_valid && (in_op == gcsc_pkg::OP_FRAME);
    cmd.tick_ld  = (state_r == S_IDLE) && in_valid && (in_op == gcsc_pkg::OP_TICK);
    cmd.prep     = (state_r == S_PREP);
    cmd.div_step = (state_r == S_DIV);
    cmd.finish   = (state_r == S_FIN) && out_free;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd.tick_ld) state_r <= S_PREP;
        end
        S_PREP: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // Stale data needs no share, so the rest of the divider is skipped.
          if (status.stale || step_r == LAST_STEP) begin
            state_r <= S_FIN;
          end else begin
            step_r <= step_r + gcsc_pkg::DIV_CNT_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
